>>> rtl/core/sfpc_pkg.sv
// Package for the SHA-1 feedback packet cipher.
// Holds payload structs, register indexes, SHA-1 constants and the control struct.
// No dependencies.
package sfpc_pkg;

  localparam int PACKET_BYTES_DEF    = 16;
  localparam int CHALLENGE_BYTES_DEF = 32;
  localparam int CFG_IDX_W           = 3;
  localparam int CFG_DATA_W          = 64;

  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHAL0     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHAL1     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHAL2     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CHAL3     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_MID   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW   = 3'd7;

  localparam logic CMD_RESTART = 1'b0;
  localparam logic CMD_DATA    = 1'b1;

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       packet_end;
  } out_item_t;

  // controller -> datapath commands
  typedef struct packed {
    logic restart;    // load key from config
    logic byte_go;    // xor current byte, save plaintext
    logic hash_init;  // build block, load working vars
    logic round_go;   // one SHA-1 round
    logic hash_done;  // fold result into key
  } sfpc_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic last_byte;  // current byte closes the packet
    logic last_round; // round counter at 79
  } sfpc_sts_t;

  function automatic logic [31:0] rol32(input logic [31:0] x, input int n);
    rol32 = (x << n) | (x >> (32 - n));
  endfunction

endpackage

>>> rtl/core/sfpc_ctrl.sv
// Controller for the SHA-1 feedback packet cipher.
// Sequences byte transactions and the 80-round key renewal; uses sfpc_pkg.
module sfpc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_cmd,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_end,
  output sfpc_pkg::sfpc_cmd_t  cmd,
  input  sfpc_pkg::sfpc_sts_t  sts
);

  typedef enum logic [1:0] {ST_IDLE, ST_INIT, ST_ROUND} state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_end_r, out_end_nxt;
  logic   accept;

  // accept only when idle and the output register is free or draining
  assign in_ready  = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_end   = out_end_r;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_end_nxt   = out_end_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_cmd == sfpc_pkg::CMD_RESTART) begin
            cmd.restart   = 1'b1;
            out_valid_nxt = 1'b1;
            out_end_nxt   = 1'b0;
          end else begin
            cmd.byte_go = 1'b1;
            if (sts.last_byte) begin
              state_nxt = ST_INIT;
            end else begin
              out_valid_nxt = 1'b1;
              out_end_nxt   = 1'b0;
            end
          end
        end
      end
      ST_INIT: begin
        cmd.hash_init = 1'b1;
        state_nxt     = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.round_go = 1'b1;
        if (sts.last_round && !out_valid_r) begin
          cmd.hash_done = 1'b1;
          out_valid_nxt = 1'b1;
          out_end_nxt   = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      out_end_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      out_end_r   <= out_end_nxt;
    end
  end

endmodule

>>> rtl/core/sfpc_dpath.sv
// Datapath for the SHA-1 feedback packet cipher: key, packet store, SHA-1 round unit.
// Driven by sfpc_ctrl commands; uses sfpc_pkg.
module sfpc_dpath #(
  parameter int PACKET_BYTES    = sfpc_pkg::PACKET_BYTES_DEF,
  parameter int CHALLENGE_BYTES = sfpc_pkg::CHALLENGE_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                direction,
  input  logic [255:0]        challenge,
  input  logic [159:0]        init_key,
  input  logic [7:0]          in_data,
  output logic [7:0]          out_data,
  input  sfpc_pkg::sfpc_cmd_t cmd,
  output sfpc_pkg::sfpc_sts_t sts
);

  // position only runs 0..PACKET_BYTES-1
  localparam int POS_W   = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1;
  localparam int MSG_LEN = CHALLENGE_BYTES + PACKET_BYTES;

  logic [159:0]      key_r;
  logic [POS_W-1:0]  pos_r;
  logic [7:0]        pkt_r [PACKET_BYTES];
  logic [7:0]        out_data_r;
  logic [31:0]       w_r [16];
  logic [31:0]       a_r, b_r, c_r, d_r, e_r;
  logic [6:0]        rnd_r;
  logic [7:0]        kbyte, dout;
  logic [511:0]      blk;
  logic [31:0]       f, k, t, wi, wnew;

  // key byte at current position
  always_comb begin
    kbyte = key_r[159 - 8*pos_r -: 8];
    dout  = in_data ^ kbyte;
  end

  assign out_data       = out_data_r;
  assign sts.last_byte  = (32'(pos_r) + 32'd1 >= 32'(PACKET_BYTES));
  assign sts.last_round = (rnd_r == 7'd79);

  // padded message block
  always_comb begin
    blk = '0;
    for (int i = 0; i < CHALLENGE_BYTES; i++) blk[511 - 8*i -: 8] = challenge[255 - 8*i -: 8];
    for (int i = 0; i < PACKET_BYTES; i++) blk[511 - 8*(CHALLENGE_BYTES + i) -: 8] = pkt_r[i];
    blk[511 - 8*MSG_LEN -: 8] = 8'h80;
    blk[63:0] = 64'(MSG_LEN * 8);
  end

  // round function
  always_comb begin
    wi   = w_r[0];
    wnew = sfpc_pkg::rol32(w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0], 1);
    if (rnd_r < 7'd20) begin
      f = (b_r & c_r) | (~b_r & d_r); k = 32'h5A827999;
    end else if (rnd_r < 7'd40) begin
      f = b_r ^ c_r ^ d_r; k = 32'h6ED9EBA1;
    end else if (rnd_r < 7'd60) begin
      f = (b_r & c_r) | (b_r & d_r) | (c_r & d_r); k = 32'h8F1BBCDC;
    end else begin
      f = b_r ^ c_r ^ d_r; k = 32'hCA62C1D6;
    end
    t = sfpc_pkg::rol32(a_r, 5) + f + e_r + k + wi;
  end

  // packet store (no reset)
  always_ff @(posedge clk) begin
    if (cmd.byte_go) pkt_r[pos_r] <= direction ? dout : in_data;
  end

  // schedule window and working variables
  always_ff @(posedge clk) begin
    if (cmd.byte_go) out_data_r <= dout;
    else if (cmd.restart) out_data_r <= 8'h00;
    if (cmd.hash_init) begin
      for (int i = 0; i < 16; i++) w_r[i] <= blk[511 - 32*i -: 32];
      a_r <= sfpc_pkg::H0; b_r <= sfpc_pkg::H1; c_r <= sfpc_pkg::H2;
      d_r <= sfpc_pkg::H3; e_r <= sfpc_pkg::H4;
    end else if (cmd.round_go && !cmd.hash_done && rnd_r != 7'd80) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= wnew;
      a_r <= t; b_r <= a_r; c_r <= sfpc_pkg::rol32(b_r, 30); d_r <= c_r; e_r <= d_r;
    end
  end

  // control state: key, position, round counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
      pos_r <= '0;
      rnd_r <= '0;
    end else begin
      if (cmd.restart) begin
        key_r <= init_key;
        pos_r <= '0;
      end else if (cmd.byte_go) begin
        pos_r <= sts.last_byte ? '0 : pos_r + POS_W'(1);
      end
      if (cmd.hash_init) rnd_r <= '0;
      else if (cmd.round_go && rnd_r != 7'd80) rnd_r <= rnd_r + 7'd1;
      if (cmd.hash_done) begin
        key_r <= {t + sfpc_pkg::H0, a_r + sfpc_pkg::H1, sfpc_pkg::rol32(b_r, 30) + sfpc_pkg::H2,
                  c_r + sfpc_pkg::H3, d_r + sfpc_pkg::H4};
        rnd_r <= '0;
      end
    end
  end

endmodule

>>> rtl/core/sha1_feedback_packet_cipher.sv
// SHA-1 feedback packet cipher, top level.
// Timing: an ordinary byte's result is registered; the byte closing a packet
// also runs key renewal (one SHA-1 round per cycle in the shared round unit, 80 rounds).
// Throughput: 1 transaction per cycle while the output is not stalled; none during key renewal.
// Reset: synchronous active low; config, key, position and round counter clear to zero (not the packet or hash store).
module sha1_feedback_packet_cipher #(
  parameter int PACKET_BYTES    = sfpc_pkg::PACKET_BYTES_DEF,
  parameter int CHALLENGE_BYTES = sfpc_pkg::CHALLENGE_BYTES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  sfpc_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output sfpc_pkg::out_item_t                out_data,
  input  logic                               cfg_we,
  input  logic [sfpc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sfpc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic         dir_r;
  logic [255:0] chal_r;
  logic [159:0] ikey_r;
  logic [7:0]   byte_out;
  logic         end_out;
  sfpc_pkg::sfpc_cmd_t cmd;
  sfpc_pkg::sfpc_sts_t sts;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r  <= 1'b0;
      chal_r <= '0;
      ikey_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sfpc_pkg::REG_DIRECTION: dir_r <= cfg_data[0];
        sfpc_pkg::REG_CHAL0:     chal_r[255:192] <= cfg_data;
        sfpc_pkg::REG_CHAL1:     chal_r[191:128] <= cfg_data;
        sfpc_pkg::REG_CHAL2:     chal_r[127:64]  <= cfg_data;
        sfpc_pkg::REG_CHAL3:     chal_r[63:0]    <= cfg_data;
        sfpc_pkg::REG_KEY_HIGH:  ikey_r[159:96]  <= cfg_data;
        sfpc_pkg::REG_KEY_MID:   ikey_r[95:32]   <= cfg_data;
        sfpc_pkg::REG_KEY_LOW:   ikey_r[31:0]    <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  sfpc_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready,
    .in_cmd(in_data.command), .out_valid, .out_ready,
    .out_end(end_out), .cmd, .sts
  );

  sfpc_dpath #(.PACKET_BYTES(PACKET_BYTES), .CHALLENGE_BYTES(CHALLENGE_BYTES)) u_dpath (
    .clk, .rst_n, .direction(dir_r), .challenge(chal_r), .init_key(ikey_r),
    .in_data(in_data.data_byte), .out_data(byte_out), .cmd, .sts
  );

  assign out_data.out_byte   = byte_out;
  assign out_data.packet_end = end_out;

  // no new transaction while a result is pending and not drained
  a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready) else $error("accept during stall");
  // restart never reports packet end
  a_restart_clean: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.restart |=> (out_valid && !out_data.packet_end)) else $error("restart end flag");
  // key fold only at the last round
  a_fold_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.hash_done |-> sts.last_round) else $error("early fold");

endmodule
